[sv/nearest_centroid_metric_scorer_top_macros.svh]
// Assertion helpers for the scorer; clk and rst_n must be in scope.
`ifndef NEAREST_CENTROID_METRIC_SCORER_TOP_MACROS_SVH
`define NEAREST_CENTROID_METRIC_SCORER_TOP_MACROS_SVH

// Same-cycle implication.
`define NCMS_ASSERT_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define NCMS_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/ncms_pkg.sv]
package ncms_pkg;

  // Field widths
  localparam int FEAT_W   = 24;
  localparam int VERT_W   = 8;
  localparam int VSC_W    = 16;   // vertex count scaled by 256
  localparam int CLASS_W  = 2;
  localparam int ACC_W    = 14;
  localparam int CNT_W    = 8;
  localparam int IDX_W    = 3;
  localparam int CFG_W    = 24;
  localparam int DIVD_W   = 22;   // hits * 10000 fits here
  localparam int SQ_N     = 6;    // squared differences per object
  localparam int SQ_CNT_W = 3;

  localparam logic [ACC_W-1:0] ACC_FULL    = 14'd10000;
  localparam logic [CNT_W-1:0] BATCH_RESET = 8'd10;

  // Register map
  typedef enum logic [IDX_W-1:0] {
    REG_C1_AREA  = 3'd0,
    REG_C1_PERIM = 3'd1,
    REG_C1_VERT  = 3'd2,
    REG_C2_AREA  = 3'd3,
    REG_C2_PERIM = 3'd4,
    REG_C2_VERT  = 3'd5,
    REG_BATCH    = 3'd6
  } reg_idx_t;

  // Decision codes
  localparam logic [CLASS_W-1:0] CLS_TIE = 2'd0;
  localparam logic [CLASS_W-1:0] CLS_C1  = 2'd1;
  localparam logic [CLASS_W-1:0] CLS_C2  = 2'd2;

  // Metric codes
  localparam logic [1:0] MET_CHEB = 2'd0;
  localparam logic [1:0] MET_MANH = 2'd1;
  localparam logic [1:0] MET_EUCL = 2'd2;

  // Control of the square-accumulate unit
  typedef struct packed {
    logic clr;
    logic mul_en;
    logic acc_en;
    logic acc_sel;
  } sq_ctl_t;

  function automatic logic [CLASS_W-1:0] decide(input logic lt, input logic gt);
    return lt ? CLS_C1 : (gt ? CLS_C2 : CLS_TIE);
  endfunction

endpackage

[sv/ncms_in_if.sv]
interface ncms_in_if;
  import ncms_pkg::*;
  logic                valid;
  logic                ready;
  logic [FEAT_W-1:0]   obj_area;
  logic [FEAT_W-1:0]   obj_perimeter;
  logic [VERT_W-1:0]   obj_vertices;
  logic [CLASS_W-1:0]  true_class;

  modport source (output valid, obj_area, obj_perimeter, obj_vertices, true_class,
                  input ready);
  modport sink   (input valid, obj_area, obj_perimeter, obj_vertices, true_class,
                  output ready);
endinterface

[sv/ncms_out_if.sv]
interface ncms_out_if;
  import ncms_pkg::*;
  logic               valid;
  logic               ready;
  logic [CLASS_W-1:0] class_cheb;
  logic [CLASS_W-1:0] class_manh;
  logic [CLASS_W-1:0] class_eucl;
  logic               batch_done;
  logic [ACC_W-1:0]   acc_cheb;
  logic [ACC_W-1:0]   acc_manh;
  logic [ACC_W-1:0]   acc_eucl;
  logic [1:0]         best_metric;

  modport source (output valid, class_cheb, class_manh, class_eucl, batch_done,
                  acc_cheb, acc_manh, acc_eucl, best_metric, input ready);
  modport sink   (input valid, class_cheb, class_manh, class_eucl, batch_done,
                  acc_cheb, acc_manh, acc_eucl, best_metric, output ready);
endinterface

[sv/ncms_cfg_if.sv]
interface ncms_cfg_if;
  import ncms_pkg::*;
  logic             valid;
  logic             ready;
  logic [IDX_W-1:0] index;
  logic [CFG_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

[sv/ncms_sq.sv]
module ncms_sq #(
  parameter int DW = 24
) (
  input  logic                 clk,
  input  ncms_pkg::sq_ctl_t    ctl,
  input  logic [DW-1:0]        op,
  output logic [2*DW+1:0]      acc0,
  output logic [2*DW+1:0]      acc1
);
  import ncms_pkg::*;

  localparam int SW = 2*DW + 2;

  logic [2*DW-1:0] prod_r;
  logic [SW-1:0]   acc0_r;
  logic [SW-1:0]   acc1_r;

  // Square, registered
  always_ff @(posedge clk) begin
    if (ctl.mul_en) begin
      prod_r <= op * op;
    end
  end

  // Accumulate into the sum of the selected centroid
  always_ff @(posedge clk) begin
    if (ctl.clr) begin
      acc0_r <= '0;
      acc1_r <= '0;
    end else if (ctl.acc_en) begin
      if (ctl.acc_sel) begin
        acc1_r <= acc1_r + SW'(prod_r);
      end else begin
        acc0_r <= acc0_r + SW'(prod_r);
      end
    end
  end

  assign acc0 = acc0_r;
  assign acc1 = acc1_r;
endmodule

[sv/ncms_div.sv]
module ncms_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [ncms_pkg::DIVD_W-1:0] dividend,
  input  logic [ncms_pkg::CNT_W-1:0]  divisor,
  output logic                        done,
  output logic [ncms_pkg::DIVD_W-1:0] quotient
);
  import ncms_pkg::*;

  localparam int DCNT_W = $clog2(DIVD_W + 1);

  logic              busy_r;
  logic              done_r;
  logic [DCNT_W-1:0] cnt_r;
  logic [CNT_W-1:0]  rem_r;
  logic [DIVD_W-1:0] quo_r;
  logic [CNT_W:0]    trial;
  logic              ge;

  // One restoring step: shift in the next dividend bit, subtract if it fits
  always_comb begin
    trial = {rem_r, quo_r[DIVD_W-1]};
    ge    = (trial >= {1'b0, divisor});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= DCNT_W'(DIVD_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == DCNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= dividend;
    end else if (busy_r) begin
      rem_r <= ge ? CNT_W'(trial - {1'b0, divisor}) : trial[CNT_W-1:0];
      quo_r <= {quo_r[DIVD_W-2:0], ge};
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;
endmodule

[sv/nearest_centroid_metric_scorer_top.sv]
// Each input word passes the difference, square-accumulate and decision states;
// the square-accumulate unit takes one squared difference per cycle, six per word.
// A new input word is taken only once the result word is handed off; the last
// word of a batch adds three 22-step restoring divisions in the shared divider.
// Reset (rst_n, synchronous, active low): registers to defaults (batch size 10),
// counters to zero, output empty; no clearing pass.
`include "nearest_centroid_metric_scorer_top_macros.svh"

module nearest_centroid_metric_scorer_top #(
  parameter int FEATURE_WIDTH = 24,
  parameter int MAX_BATCH     = 255
) (
  input  logic        clk,
  input  logic        rst_n,
  ncms_in_if.sink     in_ch,
  ncms_out_if.source  out_ch,
  ncms_cfg_if.sink    cfg_ch
);
  import ncms_pkg::*;

  localparam int FW = (FEATURE_WIDTH < FEAT_W) ? FEATURE_WIDTH : FEAT_W;
  localparam int DW = (FW > VSC_W) ? FW : VSC_W;
  localparam int SW = 2*DW + 2;
  localparam int MW = DW + 2;
  localparam logic [CNT_W-1:0] MAXB_C =
    (MAX_BATCH < (1 << CNT_W) - 1) ? CNT_W'(MAX_BATCH) : '1;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_DIFF = 6'b000010,
    S_SQ   = 6'b000100,
    S_DEC  = 6'b001000,
    S_DIV  = 6'b010000,
    S_DONE = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  // Configuration registers
  logic [FEAT_W-1:0] c1_area_r, c1_perim_r, c2_area_r, c2_perim_r;
  logic [VERT_W-1:0] c1_vert_r, c2_vert_r;
  logic [CNT_W-1:0]  batch_size_r;

  // Object and working registers
  logic [FW-1:0]       obj_a_r, obj_p_r;
  logic [VERT_W-1:0]   obj_v_r;
  logic [CLASS_W-1:0]  label_r;
  logic [DW-1:0]       diff_r [SQ_N];
  logic [SQ_CNT_W-1:0] cnt_r;
  logic [CLASS_W-1:0]  kc_r, km_r, ke_r;
  logic [CNT_W-1:0]    seen_r, hits_c_r, hits_m_r, hits_e_r;
  logic                batch_end_r;
  logic [1:0]          met_r;
  logic                div_go_r;
  logic [ACC_W-1:0]    acc_r [3];

  // Output register
  logic               out_valid_r;
  logic [CLASS_W-1:0] out_kc_r, out_km_r, out_ke_r;
  logic               out_done_r;
  logic [ACC_W-1:0]   out_ac_r, out_am_r, out_ae_r;
  logic [1:0]         out_best_r;

  // Configuration write port
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c1_area_r    <= '0;
      c1_perim_r   <= '0;
      c1_vert_r    <= '0;
      c2_area_r    <= '0;
      c2_perim_r   <= '0;
      c2_vert_r    <= '0;
      batch_size_r <= BATCH_RESET;
    end else if (cfg_ch.valid) begin
      unique case (reg_idx_t'(cfg_ch.index))
        REG_C1_AREA:  c1_area_r    <= cfg_ch.data;
        REG_C1_PERIM: c1_perim_r   <= cfg_ch.data;
        REG_C1_VERT:  c1_vert_r    <= cfg_ch.data[VERT_W-1:0];
        REG_C2_AREA:  c2_area_r    <= cfg_ch.data;
        REG_C2_PERIM: c2_perim_r   <= cfg_ch.data;
        REG_C2_VERT:  c2_vert_r    <= cfg_ch.data[VERT_W-1:0];
        REG_BATCH:    batch_size_r <= cfg_ch.data[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Absolute differences, centroid 1 in slots 0..2, centroid 2 in 3..5
  logic [DW-1:0] opx [SQ_N];
  logic [DW-1:0] opy [SQ_N];
  logic [DW-1:0] dabs [SQ_N];

  always_comb begin
    opx[0] = DW'(obj_a_r);
    opx[1] = DW'(obj_p_r);
    opx[2] = DW'({obj_v_r, 8'h00});
    opx[3] = opx[0];
    opx[4] = opx[1];
    opx[5] = opx[2];
    opy[0] = DW'(c1_area_r[FW-1:0]);
    opy[1] = DW'(c1_perim_r[FW-1:0]);
    opy[2] = DW'({c1_vert_r, 8'h00});
    opy[3] = DW'(c2_area_r[FW-1:0]);
    opy[4] = DW'(c2_perim_r[FW-1:0]);
    opy[5] = DW'({c2_vert_r, 8'h00});
    for (int i = 0; i < SQ_N; i++) begin
      dabs[i] = (opx[i] > opy[i]) ? opx[i] - opy[i] : opy[i] - opx[i];
    end
  end

  // Chebyshev and Manhattan from the stored differences
  logic [DW-1:0] cheb0, cheb1;
  logic [MW-1:0] manh0, manh1;

  always_comb begin
    cheb0 = diff_r[2];
    if (diff_r[0] > cheb0) cheb0 = diff_r[0];
    if (diff_r[1] > cheb0) cheb0 = diff_r[1];
    cheb1 = diff_r[5];
    if (diff_r[3] > cheb1) cheb1 = diff_r[3];
    if (diff_r[4] > cheb1) cheb1 = diff_r[4];
    manh0 = MW'(diff_r[0]) + MW'(diff_r[1]) + MW'(diff_r[2]);
    manh1 = MW'(diff_r[3]) + MW'(diff_r[4]) + MW'(diff_r[5]);
  end

  // Shared square-accumulate unit
  sq_ctl_t             sq_ctl;
  logic [SQ_CNT_W-1:0] sq_idx;
  logic [SW-1:0]       eucl0, eucl1;

  always_comb begin
    sq_ctl.clr     = (state_r == S_DIFF);
    sq_ctl.mul_en  = (state_r == S_SQ) && (cnt_r < SQ_CNT_W'(SQ_N));
    sq_ctl.acc_en  = (state_r == S_SQ) && (cnt_r != '0);
    sq_ctl.acc_sel = (cnt_r > SQ_CNT_W'(3));
    sq_idx         = (cnt_r < SQ_CNT_W'(SQ_N)) ? cnt_r : '0;
  end

  ncms_sq #(.DW(DW)) u_sq (
    .clk  (clk),
    .ctl  (sq_ctl),
    .op   (diff_r[sq_idx]),
    .acc0 (eucl0),
    .acc1 (eucl1)
  );

  // Batch bookkeeping
  logic [CNT_W-1:0] batch_one, batch_eff;
  logic [CNT_W:0]   seen_sum;
  logic             batch_end;
  logic [CNT_W-1:0] hits_c_upd, hits_m_upd, hits_e_upd;
  logic [CLASS_W-1:0] ke;

  always_comb begin
    batch_one  = (batch_size_r == '0) ? CNT_W'(1) : batch_size_r;
    batch_eff  = (batch_one > MAXB_C) ? MAXB_C : batch_one;
    seen_sum   = {1'b0, seen_r} + 1'b1;
    batch_end  = (seen_sum >= {1'b0, batch_eff});
    ke         = decide(eucl0 < eucl1, eucl0 > eucl1);
    hits_c_upd = hits_c_r + CNT_W'(kc_r == label_r);
    hits_m_upd = hits_m_r + CNT_W'(km_r == label_r);
    hits_e_upd = hits_e_r + CNT_W'(ke == label_r);
  end

  // Accuracy division, one metric at a time
  logic [CNT_W-1:0]  hits_sel;
  logic [DIVD_W-1:0] dividend;
  logic              div_done;
  logic [DIVD_W-1:0] quotient;
  logic [ACC_W-1:0]  acc_clamped;

  always_comb begin
    case (met_r)
      MET_CHEB: hits_sel = hits_c_r;
      MET_MANH: hits_sel = hits_m_r;
      default:  hits_sel = hits_e_r;
    endcase
    dividend    = DIVD_W'(hits_sel) * DIVD_W'(ACC_FULL);
    acc_clamped = (quotient > DIVD_W'(ACC_FULL)) ? ACC_FULL : quotient[ACC_W-1:0];
  end

  ncms_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_go_r),
    .dividend (dividend),
    .divisor  (batch_eff),
    .done     (div_done),
    .quotient (quotient)
  );

  // Result hand-off
  logic       out_load;
  logic [1:0] best;

  always_comb begin
    out_load = (state_r == S_DONE) && (!out_valid_r || out_ch.ready);
    if (!batch_end_r) begin
      best = MET_CHEB;
    end else if (acc_r[0] > acc_r[1] && acc_r[0] > acc_r[2]) begin
      best = MET_CHEB;
    end else if (acc_r[1] > acc_r[2]) begin
      best = MET_MANH;
    end else begin
      best = MET_EUCL;
    end
  end

  // Sequencer next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (in_ch.valid) state_nxt = S_DIFF;
      S_DIFF: state_nxt = S_SQ;
      S_SQ:   if (cnt_r == SQ_CNT_W'(SQ_N)) state_nxt = S_DEC;
      S_DEC:  state_nxt = batch_end ? S_DIV : S_DONE;
      S_DIV:  if (div_done && met_r == MET_EUCL) state_nxt = S_DONE;
      S_DONE: if (out_load) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  assign in_ch.ready = (state_r == S_IDLE);

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      seen_r      <= '0;
      hits_c_r    <= '0;
      hits_m_r    <= '0;
      hits_e_r    <= '0;
      batch_end_r <= 1'b0;
      met_r       <= MET_CHEB;
      div_go_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      div_go_r <= 1'b0;
      if (state_r == S_DIFF) begin
        cnt_r <= '0;
      end
      if (state_r == S_SQ) begin
        cnt_r <= cnt_r + 1'b1;
      end
      if (state_r == S_DEC) begin
        hits_c_r <= hits_c_upd;
        hits_m_r <= hits_m_upd;
        hits_e_r <= hits_e_upd;
        batch_end_r <= batch_end;
        if (batch_end) begin
          seen_r   <= '0;
          met_r    <= MET_CHEB;
          div_go_r <= 1'b1;
        end else begin
          seen_r <= seen_sum[CNT_W-1:0];
        end
      end
      if (state_r == S_DIV && div_done) begin
        if (met_r == MET_EUCL) begin
          hits_c_r <= '0;
          hits_m_r <= '0;
          hits_e_r <= '0;
        end else begin
          met_r    <= met_r + 1'b1;
          div_go_r <= 1'b1;
        end
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      obj_a_r <= in_ch.obj_area[FW-1:0];
      obj_p_r <= in_ch.obj_perimeter[FW-1:0];
      obj_v_r <= in_ch.obj_vertices;
      label_r <= in_ch.true_class;
    end
    if (state_r == S_DIFF) begin
      for (int i = 0; i < SQ_N; i++) begin
        diff_r[i] <= dabs[i];
      end
    end
    if (state_r == S_SQ && cnt_r == '0) begin
      kc_r <= decide(cheb0 < cheb1, cheb0 > cheb1);
      km_r <= decide(manh0 < manh1, manh0 > manh1);
    end
    if (state_r == S_DEC) begin
      ke_r <= ke;
      if (!batch_end) begin
        for (int i = 0; i < 3; i++) begin
          acc_r[i] <= '0;
        end
      end
    end
    if (state_r == S_DIV && div_done) begin
      acc_r[met_r] <= acc_clamped;
    end
    if (out_load) begin
      out_kc_r   <= kc_r;
      out_km_r   <= km_r;
      out_ke_r   <= ke_r;
      out_done_r <= batch_end_r;
      out_ac_r   <= acc_r[0];
      out_am_r   <= acc_r[1];
      out_ae_r   <= acc_r[2];
      out_best_r <= best;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.class_cheb  = out_kc_r;
  assign out_ch.class_manh  = out_km_r;
  assign out_ch.class_eucl  = out_ke_r;
  assign out_ch.batch_done  = out_done_r;
  assign out_ch.acc_cheb    = out_ac_r;
  assign out_ch.acc_manh    = out_am_r;
  assign out_ch.acc_eucl    = out_ae_r;
  assign out_ch.best_metric = out_best_r;

  // Checks
  `NCMS_ASSERT_NXT(a_busy_after_accept, in_ch.valid && in_ch.ready, !in_ch.ready, "ready after accept")
  `NCMS_ASSERT_NOW(a_idle_fields_zero, out_ch.valid && !out_ch.batch_done, out_ch.acc_cheb == '0 && out_ch.acc_manh == '0 && out_ch.acc_eucl == '0 && out_ch.best_metric == MET_CHEB, "accuracy fields set off batch end")
  `NCMS_ASSERT_NOW(a_acc_bound, out_ch.valid, out_ch.acc_cheb <= ACC_FULL && out_ch.acc_manh <= ACC_FULL && out_ch.acc_eucl <= ACC_FULL, "accuracy above full scale")
  `NCMS_ASSERT_NOW(a_best_cheb, out_ch.valid && out_ch.batch_done && out_ch.best_metric == MET_CHEB, out_ch.acc_cheb > out_ch.acc_manh && out_ch.acc_cheb > out_ch.acc_eucl, "wrong best metric")
endmodule

[tb/nearest_centroid_metric_scorer_top_test.sv]
`timescale 1ns / 100ps

module nearest_centroid_metric_scorer_top_test;
  import ncms_pkg::*;

  localparam logic [IDX_W-1:0]   REG_UNUSED    = 3'd7;  // no register behind it
  localparam logic [CLASS_W-1:0] LABEL_NONE    = 2'd3;  // label that never matches
  localparam logic [FEAT_W-1:0]  FEAT_MAX      = {FEAT_W{1'b1}};
  localparam int unsigned        MAX_BATCH_CAP = 255;
  localparam int                 RANDOM_ITEMS  = 1200;
  localparam int                 QUIET_LIMIT   = 4000;
  localparam int                 TAIL_CYCLES   = 100;

  // directed centroid 2; centroid 1 sits at the origin
  localparam logic [FEAT_W-1:0] SPLIT_C2_AREA  = 24'h001100;
  localparam logic [FEAT_W-1:0] SPLIT_C2_PERIM = 24'h000800;

  typedef struct packed {
    logic [FEAT_W-1:0]  area;
    logic [FEAT_W-1:0]  perim;
    logic [VERT_W-1:0]  verts;
    logic [CLASS_W-1:0] label;
  } object_t;

  typedef struct packed {
    logic [CLASS_W-1:0] cheb;
    logic [CLASS_W-1:0] manh;
    logic [CLASS_W-1:0] eucl;
    logic               done;
    logic [ACC_W-1:0]   acc_cheb;
    logic [ACC_W-1:0]   acc_manh;
    logic [ACC_W-1:0]   acc_eucl;
    logic [1:0]         best;
  } score_t;

  logic clk;
  logic rst_n;

  ncms_in_if  in_ch();
  ncms_out_if out_ch();
  ncms_cfg_if cfg_ch();

  nearest_centroid_metric_scorer_top dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // shadow of the register file and the batch counters
  logic [FEAT_W-1:0] cen_area [2];
  logic [FEAT_W-1:0] cen_perim [2];
  logic [VERT_W-1:0] cen_verts [2];
  logic [CNT_W-1:0]  batch_reg;
  int unsigned       batch_count, cheb_hits, manh_hits, eucl_hits;

  object_t pending_objects[$];
  score_t  expected_scores[$];

  object_t in_obj;
  bit      in_busy;
  int      in_gap;
  int      stall_left;
  bit      in_calm, out_calm;
  int      error_count;
  int      quiet_cycles;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  task automatic flag_error(input string msg);
    $display("mismatch @%0t: %s", $time, msg);
    error_count++;
  endtask

  // mostly no pause, some short ones, a few long ones
  function automatic int next_pause(input bit calm);
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 75) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [FEAT_W-1:0] abs_gap(input logic [FEAT_W-1:0] x,
                                                input logic [FEAT_W-1:0] y);
    return (x > y) ? x - y : y - x;
  endfunction

  function automatic logic [CLASS_W-1:0] nearer(input logic [2*FEAT_W+1:0] d1,
                                                input logic [2*FEAT_W+1:0] d2);
    if (d1 < d2) return CLS_C1;
    if (d1 > d2) return CLS_C2;
    return CLS_TIE;
  endfunction

  // floor(hits * 10000 / batch), capped at full score
  function automatic logic [ACC_W-1:0] hundredths(input int unsigned hits,
                                                  input int unsigned lim);
    int unsigned a;
    a = hits * 10000 / lim;
    return (a > ACC_FULL) ? ACC_FULL : a[ACC_W-1:0];
  endfunction

  // classify one object against both centroids and update the batch tallies
  task automatic score_object(input object_t o);
    logic [FEAT_W-1:0]   da, dp, dv;
    logic [2*FEAT_W+1:0] cheb [2];
    logic [2*FEAT_W+1:0] manh [2];
    logic [2*FEAT_W+1:0] eucl [2];
    score_t              s;
    int unsigned         lim;
    for (int k = 0; k < 2; k++) begin
      da = abs_gap(o.area, cen_area[k]);
      dp = abs_gap(o.perim, cen_perim[k]);
      dv = abs_gap({o.verts, 8'h00}, {cen_verts[k], 8'h00});
      cheb[k] = (da > dp) ? da : dp;
      if (dv > cheb[k]) cheb[k] = dv;
      manh[k] = da + dp + dv;
      eucl[k] = da * da + dp * dp + dv * dv;
    end
    s = '0;
    s.cheb = nearer(cheb[0], cheb[1]);
    s.manh = nearer(manh[0], manh[1]);
    s.eucl = nearer(eucl[0], eucl[1]);
    if (s.cheb == o.label) cheb_hits++;
    if (s.manh == o.label) manh_hits++;
    if (s.eucl == o.label) eucl_hits++;
    batch_count++;
    // zero batch acts as one; a shrunk batch closes at once
    lim = (batch_reg == 0) ? 1 : batch_reg;
    if (lim > MAX_BATCH_CAP) lim = MAX_BATCH_CAP;
    if (batch_count >= lim) begin
      s.done     = 1'b1;
      s.acc_cheb = hundredths(cheb_hits, lim);
      s.acc_manh = hundredths(manh_hits, lim);
      s.acc_eucl = hundredths(eucl_hits, lim);
      if (s.acc_cheb > s.acc_manh && s.acc_cheb > s.acc_eucl) s.best = MET_CHEB;
      else if (s.acc_manh > s.acc_eucl) s.best = MET_MANH;
      else s.best = MET_EUCL;
      batch_count = 0;
      cheb_hits   = 0;
      manh_hits   = 0;
      eucl_hits   = 0;
    end
    expected_scores.push_back(s);
  endtask

  function automatic object_t mk(input logic [FEAT_W-1:0] area,
                                 input logic [FEAT_W-1:0] perim,
                                 input logic [VERT_W-1:0] verts,
                                 input logic [CLASS_W-1:0] label);
    object_t o;
    o.area  = area;
    o.perim = perim;
    o.verts = verts;
    o.label = label;
    return o;
  endfunction

  // signed offset of random magnitude, up to a few thousand
  function automatic logic [FEAT_W-1:0] jitter();
    int unsigned       span;
    logic [FEAT_W-1:0] d;
    span = 1 << $urandom_range(0, 12);
    d = $urandom_range(0, span);
    return $urandom_range(0, 1) ? -d : d;
  endfunction

  // random object: anywhere, near a centroid, or on/near the midpoint
  function automatic object_t random_object();
    object_t o;
    int      k, pick, r;
    k = $urandom_range(0, 1);
    pick = $urandom_range(0, 99);
    if (pick < 30) begin
      o.area  = $urandom;
      o.perim = $urandom;
      o.verts = $urandom;
    end else if (pick < 70) begin
      o.area  = cen_area[k] + jitter();
      o.perim = cen_perim[k] + jitter();
      o.verts = cen_verts[k] + 8'($urandom_range(0, 6)) - 8'd3;
    end else begin
      o.area  = ({1'b0, cen_area[0]} + {1'b0, cen_area[1]}) >> 1;
      o.perim = ({1'b0, cen_perim[0]} + {1'b0, cen_perim[1]}) >> 1;
      o.verts = ({1'b0, cen_verts[0]} + {1'b0, cen_verts[1]}) >> 1;
      if (pick >= 85) o.area = o.area + ($urandom_range(0, 1) ? 24'd1 : FEAT_MAX);
    end
    r = $urandom_range(0, 99);
    if (r < 40) o.label = CLS_C1;
    else if (r < 80) o.label = CLS_C2;
    else if (r < 90) o.label = CLS_TIE;
    else o.label = LABEL_NONE;
    return o;
  endfunction

  // one register write on the config channel; shadow updated at the handshake
  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    repeat ($urandom_range(0, 2)) @(posedge clk);
    @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    case (idx)
      REG_C1_AREA:  cen_area[0]  = val;
      REG_C1_PERIM: cen_perim[0] = val;
      REG_C1_VERT:  cen_verts[0] = val[VERT_W-1:0];
      REG_C2_AREA:  cen_area[1]  = val;
      REG_C2_PERIM: cen_perim[1] = val;
      REG_C2_VERT:  cen_verts[1] = val[VERT_W-1:0];
      REG_BATCH:    batch_reg    = val[CNT_W-1:0];
      default: ;
    endcase
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic wait_idle();
    while (pending_objects.size() != 0 || in_busy || expected_scores.size() != 0)
      @(posedge clk);
  endtask

  function automatic bit coin();
    return $urandom_range(0, 9) < 7;
  endfunction

  // new random centroids and batch size; some registers may keep their value
  task automatic new_setup(input bit write_all);
    logic [CFG_W-1:0] area_v [2];
    logic [CFG_W-1:0] perim_v [2];
    logic [CFG_W-1:0] vert_v [2];
    logic [CNT_W-1:0] b;
    int               style, r;
    style = $urandom_range(0, 3);
    for (int k = 0; k < 2; k++) begin
      area_v[k]  = $urandom;
      perim_v[k] = $urandom;
      vert_v[k]  = $urandom;
      if (k == 1 && style == 1) begin
        // clustered centroids
        area_v[1]  = area_v[0] + jitter();
        perim_v[1] = perim_v[0] + jitter();
        vert_v[1]  = {16'($urandom), 8'(vert_v[0][VERT_W-1:0] + $urandom_range(0, 4))};
      end else if (style == 2) begin
        // corners of the feature space
        area_v[k]  = $urandom_range(0, 1) ? FEAT_MAX : '0;
        perim_v[k] = $urandom_range(0, 1) ? FEAT_MAX : '0;
        vert_v[k]  = {16'($urandom), $urandom_range(0, 1) ? 8'hFF : 8'h00};
      end else if (k == 1 && style == 3) begin
        // identical centroids, every decision ties
        area_v[1]  = area_v[0];
        perim_v[1] = perim_v[0];
        vert_v[1]  = vert_v[0];
      end
    end
    r = $urandom_range(0, 99);
    if (r < 10) b = 8'd0;
    else if (r < 20) b = 8'd1;
    else if (r < 25) b = 8'd255;
    else b = $urandom_range(2, 20);

    if (write_all || coin()) write_reg(REG_C1_AREA, area_v[0]);
    if (write_all || coin()) write_reg(REG_C1_PERIM, perim_v[0]);
    if (write_all || coin()) write_reg(REG_C1_VERT, vert_v[0]);
    if (write_all || coin()) write_reg(REG_C2_AREA, area_v[1]);
    if (write_all || coin()) write_reg(REG_C2_PERIM, perim_v[1]);
    if (write_all || coin()) write_reg(REG_C2_VERT, vert_v[1]);
    if (write_all || coin()) write_reg(REG_BATCH, {16'($urandom), b});
    if ($urandom_range(0, 99) < 15) write_reg(REG_UNUSED, $urandom);
    in_calm  = ($urandom_range(0, 3) == 0);
    out_calm = ($urandom_range(0, 3) == 0);
  endtask

  // input driver: one object word at a time from the pending queue
  always @(posedge clk) begin : feeder
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      in_busy = 1'b0;
      in_gap  = 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        score_object(in_obj);
        in_busy = 1'b0;
      end
      if (!in_busy) begin
        if (in_gap > 0) begin
          in_gap--;
        end else if (pending_objects.size() != 0) begin
          in_obj = pending_objects.pop_front();
          in_ch.obj_area      <= in_obj.area;
          in_ch.obj_perimeter <= in_obj.perim;
          in_ch.obj_vertices  <= in_obj.verts;
          in_ch.true_class    <= in_obj.label;
          in_busy = 1'b1;
          in_gap  = next_pause(in_calm);
        end
      end
      in_ch.valid <= in_busy;
    end
  end

  task automatic check_field(input string name, input logic [ACC_W-1:0] got,
                             input logic [ACC_W-1:0] want);
    if (got !== want) flag_error($sformatf("%s got %0d want %0d", name, got, want));
  endtask

  // result monitor with random back-pressure
  always @(posedge clk) begin : collector
    score_t got, want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        got.cheb     = out_ch.class_cheb;
        got.manh     = out_ch.class_manh;
        got.eucl     = out_ch.class_eucl;
        got.done     = out_ch.batch_done;
        got.acc_cheb = out_ch.acc_cheb;
        got.acc_manh = out_ch.acc_manh;
        got.acc_eucl = out_ch.acc_eucl;
        got.best     = out_ch.best_metric;
        if (expected_scores.size() == 0) begin
          flag_error("result word with nothing expected");
        end else begin
          want = expected_scores.pop_front();
          check_field("class_cheb", got.cheb, want.cheb);
          check_field("class_manh", got.manh, want.manh);
          check_field("class_eucl", got.eucl, want.eucl);
          check_field("batch_done", got.done, want.done);
          check_field("acc_cheb", got.acc_cheb, want.acc_cheb);
          check_field("acc_manh", got.acc_manh, want.acc_manh);
          check_field("acc_eucl", got.acc_eucl, want.acc_eucl);
          check_field("best_metric", got.best, want.best);
        end
      end
      if (stall_left > 0) stall_left--;
      else stall_left = next_pause(out_calm);
      out_ch.ready <= (stall_left == 0);
    end
  end

  // watchdog: too long without any word moving on any channel
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    object_t split_a, split_b;
    int      random_sent, count;
    bit      first_setup;

    rst_n               = 1'b0;
    in_ch.valid         = 1'b0;
    in_ch.obj_area      = '0;
    in_ch.obj_perimeter = '0;
    in_ch.obj_vertices  = '0;
    in_ch.true_class    = '0;
    out_ch.ready        = 1'b0;
    cfg_ch.valid        = 1'b0;
    cfg_ch.index        = '0;
    cfg_ch.data         = '0;
    quiet_cycles        = 0;
    error_count         = 0;
    in_calm             = 1'b0;
    out_calm            = 1'b0;
    for (int k = 0; k < 2; k++) begin
      cen_area[k]  = '0;
      cen_perim[k] = '0;
      cen_verts[k] = '0;
    end
    batch_reg   = BATCH_RESET;
    batch_count = 0;
    cheb_hits   = 0;
    manh_hits   = 0;
    eucl_hits   = 0;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings: both centroids at zero so all metrics tie; batch of ten
    pending_objects.push_back(mk('0, '0, 8'h00, CLS_TIE));
    pending_objects.push_back(mk(FEAT_MAX, FEAT_MAX, 8'hFF, LABEL_NONE));
    pending_objects.push_back(mk(FEAT_MAX, '0, 8'h00, CLS_C1));
    pending_objects.push_back(mk('0, FEAT_MAX, 8'hFF, CLS_C2));
    repeat (6) pending_objects.push_back(random_object());
    wait_idle();

    // split point A: Chebyshev says c1, the others c2
    // split point B: Manhattan says c2, the others c1
    split_a = mk(24'h000800, 24'h000800, 8'h00, CLS_C1);
    split_b = mk(24'h000600, 24'h000800, 8'h00, CLS_C2);
    write_reg(REG_C1_AREA, '0);
    write_reg(REG_C1_PERIM, '0);
    write_reg(REG_C1_VERT, '0);
    write_reg(REG_C2_AREA, SPLIT_C2_AREA);
    write_reg(REG_C2_PERIM, SPLIT_C2_PERIM);
    write_reg(REG_C2_VERT, {16'hFFFF, 8'h00});
    write_reg(REG_BATCH, '0);  // zero batch: every word closes a batch
    write_reg(REG_UNUSED, 24'h000003);
    pending_objects.push_back(split_a);
    pending_objects.push_back(split_b);
    pending_objects.push_back(mk(24'h000880, 24'h000400, 8'h00, CLS_TIE));
    pending_objects.push_back(mk(FEAT_MAX, FEAT_MAX, 8'hFF, LABEL_NONE));
    wait_idle();

    // batches of three steering the best-metric pick to each metric
    write_reg(REG_BATCH, 24'd3);
    repeat (3) pending_objects.push_back(split_a);
    split_b.label = CLS_C2;
    repeat (3) pending_objects.push_back(split_b);
    split_a.label = CLS_C2;
    repeat (3) pending_objects.push_back(split_a);
    wait_idle();

    // batch shrunk mid-batch: accuracy saturates
    write_reg(REG_BATCH, 24'd5);
    split_a.label = CLS_C1;
    repeat (3) pending_objects.push_back(split_a);
    wait_idle();
    write_reg(REG_BATCH, 24'd2);
    pending_objects.push_back(split_a);
    wait_idle();

    // random phases, each under a fresh setup
    random_sent = 0;
    first_setup = 1'b1;
    while (random_sent < RANDOM_ITEMS) begin
      new_setup(first_setup);
      first_setup = 1'b0;
      count = $urandom_range(30, 90);
      repeat (count) pending_objects.push_back(random_object());
      random_sent += count;
      wait_idle();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    if (error_count == 0 && expected_scores.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
